// ===== design/tsrv_pkg.sv =====
// Shared types and constants of the text scrollback ring view.
`timescale 1ns / 1ps

package tsrv_pkg;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET = 8'd25;

   typedef enum logic [1:0] {
      OP_KEEP   = 2'd0,
      OP_SCROLL = 2'd1,
      OP_BOTTOM = 2'd2,
      OP_LOCATE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_GRID = 2'd1,
      SRC_RING = 2'd2
   } source_type;

   typedef enum logic {
      CSR_COLS = 1'b0,
      CSR_ROWS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PAD,
      ST_LOOK,
      ST_MOVE
   } state_type;

endpackage

// ===== design/text_scrollback_ring_view_top.sv =====
// Top level of the text scrollback ring view: ring memory, view control and result register.
`timescale 1ns / 1ps

// One transfer in takes one operation and gives exactly one result transfer out. A character
// kept is written to the ring memory as it is taken; the character that ends a row then pads
// the rest of the row (MAX_COLUMNS minus the columns already written) with spaces, one a cycle
// through the single write port of the ring memory, before it commits the row. Scroll forms
// the product of page step and page count, then clamps the view, but skips the clamp when the
// page count or the visible row count is zero; return to bottom clears the view offset, and
// locate waits for the registered read of the ring memory. An item finishes only when the
// result register is free, so a stalled result side adds its stall. The ring memory is not
// cleared after reset: only committed rows are ever returned, so the block is ready straight out of reset.
module text_scrollback_ring_view_top #(
   parameter int HISTORY_LINES = 256,
   parameter int MAX_COLUMNS   = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_of_row,
   input  logic signed [10:0] req_page_count,
   input  logic [7:0]  req_screen_line,
   input  logic [6:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_source,
   output logic [7:0]  rsp_grid_row,
   output logic [7:0]  rsp_ring_slot,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_changed,
   output logic [8:0]  rsp_view_offset,
   output logic [8:0]  rsp_held_lines,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import tsrv_pkg::*;

   localparam int SLOT_W = $clog2(HISTORY_LINES);
   localparam int CNT_W  = $clog2(HISTORY_LINES + 1);
   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int CIDX_W = $clog2(MAX_COLUMNS);
   localparam int DEPTH  = HISTORY_LINES * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WIDE_W = CNT_W + 1;

   logic [7:0] ring_mem [DEPTH];

   state_type       state_ff, state_in;
   logic [7:0]      cols_ff, rows_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  view_ff, view_in;
   logic [COL_W-1:0]  fill_ff, fill_in;

   opcode_type      op_ff;
   logic            last_ff;
   logic signed [10:0] pages_ff;
   logic [7:0]      line_ff;
   logic [6:0]      column_ff;

   source_type      loc_src_ff, loc_src_in;
   logic [7:0]      loc_grid_ff, loc_grid_in;
   logic [SLOT_W-1:0] loc_slot_ff, loc_slot_in;
   logic            loc_colok_ff, loc_colok_in;
   logic [7:0]      rd_data_ff;

   logic [18:0]     prod_ff, prod_in;
   logic            neg_ff, neg_in;

   logic            rsp_valid_ff, rsp_valid_in;
   source_type      rsp_source_ff, res_source;
   logic [7:0]      rsp_grid_ff, res_grid;
   logic [7:0]      rsp_slot_ff, res_slot;
   logic [7:0]      rsp_char_ff, res_char;
   logic            rsp_changed_ff, res_changed;
   logic [CNT_W-1:0] rsp_view_ff, rsp_count_ff;

   logic            accept, out_free, finish;
   logic            mem_we, rd_en;
   logic [ADDR_W-1:0] mem_waddr, rd_addr;
   logic [7:0]      mem_wdata;
   logic [COL_W-1:0] fill_inc;
   logic            scroll_noop;
   logic [7:0]      page_step;
   logic [10:0]     page_mag;
   logic [WIDE_W-1:0] up_wide, back_wide;
   logic [CNT_W-1:0] up;
   logic [19:0]     want;
   logic [CNT_W-1:0] count_commit;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fill_inc  = (16'(fill_ff) < 16'(MAX_COLUMNS)) ? fill_ff + COL_W'(1) : fill_ff;
   assign scroll_noop = (pages_ff == 11'sd0) || (rows_ff == 8'd0);
   assign page_step = (rows_ff > 8'd1) ? rows_ff - 8'd1 : 8'd1;
   assign page_mag  = pages_ff[10] ? 11'(-pages_ff) : 11'(pages_ff);
   assign up        = CNT_W'(16'(view_ff) - 16'(line_ff));
   assign up_wide   = WIDE_W'(slot_ff) + WIDE_W'(HISTORY_LINES) - WIDE_W'(up);
   assign back_wide = (up_wide >= WIDE_W'(HISTORY_LINES)) ?
                      up_wide - WIDE_W'(HISTORY_LINES) : up_wide;
   assign want      = 20'(view_ff) + 20'(prod_ff);
   assign count_commit = (16'(count_ff) < 16'(HISTORY_LINES)) ? count_ff + CNT_W'(1)
                                                              : count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_KEEP: begin
                  if (last_ff) state_in = ST_PAD;
                  else if (out_free) state_in = ST_IDLE;
               end
               OP_SCROLL: begin
                  if (!scroll_noop) state_in = ST_MOVE;
                  else if (out_free) state_in = ST_IDLE;
               end
               OP_BOTTOM: begin
                  if (out_free) state_in = ST_IDLE;
               end
               OP_LOCATE: state_in = ST_LOOK;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PAD: begin
            if (16'(fill_ff) >= 16'(MAX_COLUMNS) && out_free) state_in = ST_IDLE;
         end
         ST_LOOK, ST_MOVE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and results
   always_comb begin
      finish       = 1'b0;
      slot_in      = slot_ff;
      count_in     = count_ff;
      view_in      = view_ff;
      fill_in      = fill_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      loc_src_in   = loc_src_ff;
      loc_grid_in  = loc_grid_ff;
      loc_slot_in  = loc_slot_ff;
      loc_colok_in = loc_colok_ff;
      res_source   = SRC_NONE;
      res_grid     = 8'd0;
      res_slot     = 8'd0;
      res_char     = 8'd0;
      res_changed  = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(slot_ff) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(CIDX_W'(fill_ff));
      mem_wdata    = SPACE_CHAR;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(slot_ff) * ADDR_W'(MAX_COLUMNS);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_KEEP && 16'(fill_ff) < 16'(MAX_COLUMNS)) begin
               mem_we    = 1'b1;
               mem_wdata = (16'(fill_ff) < 16'(cols_ff)) ? req_char_in : SPACE_CHAR;
            end
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_KEEP: begin
                  if (last_ff || out_free) fill_in = fill_inc;
                  finish = !last_ff && out_free;
               end
               OP_SCROLL: begin
                  prod_in = 19'(page_step) * 19'(page_mag);
                  neg_in  = pages_ff[10];
                  finish  = scroll_noop && out_free;
               end
               OP_BOTTOM: begin
                  finish      = out_free;
                  res_changed = (view_ff != '0);
                  if (out_free) view_in = '0;
               end
               OP_LOCATE: begin
                  rd_en        = 1'b1;
                  loc_src_in   = SRC_NONE;
                  loc_grid_in  = 8'd0;
                  loc_slot_in  = '0;
                  loc_colok_in = 16'(column_ff) < 16'(MAX_COLUMNS);
                  if (line_ff < rows_ff) begin
                     if (16'(view_ff) <= 16'(line_ff)) begin
                        loc_src_in  = SRC_GRID;
                        loc_grid_in = 8'(16'(line_ff) - 16'(view_ff));
                     end else if (up <= count_ff) begin
                        loc_src_in  = SRC_RING;
                        loc_slot_in = SLOT_W'(back_wide);
                     end
                  end
                  rd_addr = ADDR_W'(SLOT_W'(back_wide)) * ADDR_W'(MAX_COLUMNS)
                          + ADDR_W'(CIDX_W'(column_ff));
               end
               default: finish = 1'b0;
            endcase
         end
         ST_PAD: begin
            if (16'(fill_ff) < 16'(MAX_COLUMNS)) begin
               mem_we  = 1'b1;
               fill_in = fill_ff + COL_W'(1);
            end else if (out_free) begin
               finish   = 1'b1;
               fill_in  = '0;
               slot_in  = (32'(slot_ff) == HISTORY_LINES - 1) ? '0 : slot_ff + SLOT_W'(1);
               count_in = count_commit;
               if (view_ff != '0 && view_ff < count_commit) view_in = view_ff + CNT_W'(1);
            end
         end
         ST_LOOK: begin
            finish     = out_free;
            res_source = loc_src_ff;
            res_grid   = loc_grid_ff;
            if (loc_src_ff == SRC_RING) begin
               res_slot = 8'(loc_slot_ff);
               res_char = loc_colok_ff ? rd_data_ff : SPACE_CHAR;
            end
         end
         ST_MOVE: begin
            finish = out_free;
            if (!neg_ff) begin
               view_in = (want > 20'(count_ff)) ? count_ff : CNT_W'(want);
            end else begin
               view_in = (20'(prod_ff) >= 20'(view_ff)) ? '0 : CNT_W'(20'(view_ff) - 20'(prod_ff));
            end
            res_changed = (view_in != view_ff);
            if (!out_free) view_in = view_ff;
         end
         default: finish = 1'b0;
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
         slot_ff      <= '0;
         count_ff     <= '0;
         view_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         view_ff      <= view_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_COLS: cols_ff <= csr_wdata;
               CSR_ROWS: rows_ff <= csr_wdata;
               default:  cols_ff <= cols_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= opcode_type'(req_opcode);
         last_ff   <= req_last_of_row;
         pages_ff  <= req_page_count;
         line_ff   <= req_screen_line;
         column_ff <= req_column;
      end
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      loc_src_ff   <= loc_src_in;
      loc_grid_ff  <= loc_grid_in;
      loc_slot_ff  <= loc_slot_in;
      loc_colok_ff <= loc_colok_in;
      if (finish) begin
         rsp_source_ff  <= res_source;
         rsp_grid_ff    <= res_grid;
         rsp_slot_ff    <= res_slot;
         rsp_char_ff    <= res_char;
         rsp_changed_ff <= res_changed;
         rsp_view_ff    <= view_in;
         rsp_count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
      if (rd_en) rd_data_ff <= ring_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_source      = rsp_source_ff;
   assign rsp_grid_row    = rsp_grid_ff;
   assign rsp_ring_slot   = rsp_slot_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_changed     = rsp_changed_ff;
   assign rsp_view_offset = 9'(rsp_view_ff);
   assign rsp_held_lines  = 9'(rsp_count_ff);

endmodule

// ===== design/tsrv_checker.sv =====
// Port-level checks of the text scrollback ring view, bound to its top level.
`timescale 1ns / 1ps

module tsrv_checker #(
   parameter int HISTORY_LINES = 256
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_source,
   input logic [7:0] rsp_ring_slot,
   input logic [7:0] rsp_char_out,
   input logic       rsp_changed,
   input logic [8:0] rsp_view_offset,
   input logic [8:0] rsp_held_lines
);
   import tsrv_pkg::*;

   localparam bit NARROW = (HISTORY_LINES <= 256);

   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_view_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && NARROW |-> rsp_view_offset <= rsp_held_lines)
      else $error("view offset above held lines");

   a_ring_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source != 2'(SRC_RING) |-> rsp_ring_slot == 8'd0 && rsp_char_out == 8'd0)
      else $error("ring fields set without ring source");

   a_changed_only_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_source == 2'(SRC_NONE))
      else $error("view change reported with a located line");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_view_offset) &&
      $stable(rsp_held_lines))
      else $error("stalled result dropped or changed");

endmodule

bind text_scrollback_ring_view_top tsrv_checker #(.HISTORY_LINES(HISTORY_LINES)) u_tsrv_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_source      (rsp_source),
   .rsp_ring_slot   (rsp_ring_slot),
   .rsp_char_out    (rsp_char_out),
   .rsp_changed     (rsp_changed),
   .rsp_view_offset (rsp_view_offset),
   .rsp_held_lines  (rsp_held_lines)
);
